// File: src/id_to_endpoint_hash_table_assert.svh
// Assertion macros for the ID to endpoint hash table.
// Used inside modules that declare clk_i and rst_ni; no other dependencies.
`ifndef ID_TO_ENDPOINT_HASH_TABLE_ASSERT_SVH
`define ID_TO_ENDPOINT_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define IHT_ASSERT_NOW(label, ant, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("iht assertion failed");

// Next-cycle implication, disabled while in reset
`define IHT_ASSERT_NEXT(label, ant, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("iht assertion failed");

`endif

// File: src/iht_pkg.sv
// Package for the ID to endpoint hash table: codes, widths, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package iht_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 256;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned ENTRY_W         = 4 * WORD_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_EXEC,
    S_DONE
  } state_e;

  // entry store strobes
  typedef struct packed {
    logic key_rd;
    logic val_rd;
    logic wr;
  } emem_ctrl_t;

  // valid row store strobes
  typedef struct packed {
    logic rd;
    logic wr;
  } vmem_ctrl_t;

endpackage

// File: src/iht_if.sv
// Request and response channel interfaces for the ID to endpoint hash table.
// No dependencies.
`timescale 1ns / 1ps

interface iht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key_w0;
  logic [63:0] key_w1;
  logic [63:0] key_w2;
  logic [63:0] key_w3;
  logic [63:0] val_w0;
  logic [63:0] val_w1;
  logic [63:0] val_w2;
  logic [63:0] val_w3;

  modport source (
    output valid, opcode, key_w0, key_w1, key_w2, key_w3,
           val_w0, val_w1, val_w2, val_w3,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_w0, key_w1, key_w2, key_w3,
           val_w0, val_w1, val_w2, val_w3,
    output ready
  );
endinterface

interface iht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_w0;
  logic [63:0] out_w1;
  logic [63:0] out_w2;
  logic [63:0] out_w3;

  modport source (
    output valid, status, out_w0, out_w1, out_w2, out_w3,
    input  ready
  );
  modport sink (
    input  valid, status, out_w0, out_w1, out_w2, out_w3,
    output ready
  );
endinterface

// File: src/iht_valid_mem.sv
// Valid-bit store: one row of WAYS bits per bucket, registered read.
// Depends on iht_pkg.
`timescale 1ns / 1ps

module iht_valid_mem #(
  parameter int unsigned NUM_BUCKETS = iht_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = iht_pkg::WAYS_DEF,
  localparam int unsigned BW         = $clog2(NUM_BUCKETS)
) (
  input  logic               clk_i,
  input  iht_pkg::vmem_ctrl_t ctrl_i,
  input  logic [BW-1:0]      rd_addr_i,
  input  logic [BW-1:0]      wr_addr_i,
  input  logic [WAYS-1:0]    wr_data_i,
  output logic [WAYS-1:0]    rd_data_o
);
  import iht_pkg::*;

  logic [WAYS-1:0] mem [NUM_BUCKETS];
  logic [WAYS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/iht_entry_mem.sv
// Key and endpoint stores: one 256-bit row per slot, shared read address.
// Depends on iht_pkg.
`timescale 1ns / 1ps

module iht_entry_mem #(
  parameter int unsigned SLOTS = iht_pkg::NUM_BUCKETS_DEF * iht_pkg::WAYS_DEF,
  localparam int unsigned SW   = $clog2(SLOTS)
) (
  input  logic                         clk_i,
  input  iht_pkg::emem_ctrl_t          ctrl_i,
  input  logic [SW-1:0]                rd_addr_i,
  input  logic [SW-1:0]                wr_addr_i,
  input  logic [iht_pkg::ENTRY_W-1:0]  wr_key_i,
  input  logic [iht_pkg::ENTRY_W-1:0]  wr_val_i,
  output logic [iht_pkg::ENTRY_W-1:0]  key_rd_o,
  output logic [iht_pkg::ENTRY_W-1:0]  val_rd_o
);
  import iht_pkg::*;

  logic [ENTRY_W-1:0] key_mem [SLOTS];
  logic [ENTRY_W-1:0] val_mem [SLOTS];
  logic [ENTRY_W-1:0] key_rd_q;
  logic [ENTRY_W-1:0] val_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_rd) begin
      key_rd_q <= key_mem[rd_addr_i];
    end
    if (ctrl_i.val_rd) begin
      val_rd_q <= val_mem[rd_addr_i];
    end
  end

  assign key_rd_o = key_rd_q;
  assign val_rd_o = val_rd_q;

endmodule

// File: src/id_to_endpoint_hash_table.sv
// Exact-match table of 256-bit connection IDs to 256-bit endpoint records. Each
// request beat is an insert, lookup or remove and yields one response beat. The
// bucket is key_w1 masked to NUM_BUCKETS (a power of two); each bucket has WAYS
// entries. A sequencer walks the ways of the bucket one per cycle through a
// single 256-bit key comparator fed from the key store's registered read port.
// After accept, the probe stops at the first matching way or at the last way;
// then an execute state applies the operation and a done state holds the result. The
// response sits in an output register, so a stalled sink holds the block only
// once the next result is ready. After reset the valid rows are swept clear,
// one bucket per cycle, with the request side not ready.
// Depends on iht_pkg, iht_if, iht_valid_mem, iht_entry_mem and the assert header.
`timescale 1ns / 1ps
`include "id_to_endpoint_hash_table_assert.svh"

module id_to_endpoint_hash_table #(
  parameter int unsigned NUM_BUCKETS = iht_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = iht_pkg::WAYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iht_req_if.sink     req_i,
  iht_rsp_if.source   rsp_o
);
  import iht_pkg::*;

  localparam int unsigned BW    = $clog2(NUM_BUCKETS);
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SLOTS = NUM_BUCKETS * WAYS;
  localparam int unsigned SW    = $clog2(SLOTS);

  function automatic logic [SW-1:0] slot_of(input logic [BW-1:0] b, input logic [WW-1:0] w);
    return SW'(b) * SW'(WAYS) + SW'(w);
  endfunction

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [ENTRY_W-1:0] key_q, key_d;
  logic [ENTRY_W-1:0] val_q, val_d;
  logic [BW-1:0]    bucket_q, bucket_d;
  logic [WW-1:0]    way_q, way_d;
  logic             hit_q, hit_d;
  logic [WW-1:0]    hit_way_q, hit_way_d;
  status_e          res_q, res_d;
  logic [BW-1:0]    clr_q, clr_d;

  logic             out_vld_q, out_vld_d;
  status_e          out_status_q, out_status_d;
  logic [ENTRY_W-1:0] out_data_q, out_data_d;

  logic             accept;
  logic             cmp;
  logic             last_way;
  logic             free_found;
  logic [WW-1:0]    free_way;
  logic             load_out;

  vmem_ctrl_t       vctrl;
  logic [BW-1:0]    v_rd_addr, v_wr_addr;
  logic [WAYS-1:0]  v_wr_data, vrow;

  emem_ctrl_t       ectrl;
  logic [SW-1:0]    e_rd_addr, e_wr_addr;
  logic [ENTRY_W-1:0] key_rd, val_rd;

  iht_valid_mem #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_valid (
    .clk_i     (clk_i),
    .ctrl_i    (vctrl),
    .rd_addr_i (v_rd_addr),
    .wr_addr_i (v_wr_addr),
    .wr_data_i (v_wr_data),
    .rd_data_o (vrow)
  );

  iht_entry_mem #(
    .SLOTS (SLOTS)
  ) u_entry (
    .clk_i     (clk_i),
    .ctrl_i    (ectrl),
    .rd_addr_i (e_rd_addr),
    .wr_addr_i (e_wr_addr),
    .wr_key_i  (key_q),
    .wr_val_i  (val_q),
    .key_rd_o  (key_rd),
    .val_rd_o  (val_rd)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load_out    = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  // shared comparator: key of the way read last cycle
  assign cmp      = vrow[way_q] && (key_rd == key_q);
  assign last_way = (way_q == WW'(WAYS - 1));

  // lowest free way of the bucket
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow[w]) begin
        free_found = 1'b1;
        free_way   = WW'(w);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == BW'(NUM_BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_PROBE;
      end
      S_PROBE: begin
        if (cmp || last_way) state_d = S_EXEC;
      end
      S_EXEC:  state_d = S_DONE;
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // datapath and memory strobes
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    bucket_d     = bucket_q;
    way_d        = way_q;
    hit_d        = hit_q;
    hit_way_d    = hit_way_q;
    res_d        = res_q;
    clr_d        = clr_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;

    vctrl     = '0;
    v_rd_addr = req_i.key_w1[BW-1:0];
    v_wr_addr = bucket_q;
    v_wr_data = vrow;
    ectrl     = '0;
    e_rd_addr = slot_of(bucket_q, WW'(way_q + 1'b1));
    e_wr_addr = slot_of(bucket_q, free_way);

    if (rsp_o.valid && rsp_o.ready) out_vld_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        vctrl.wr  = 1'b1;
        v_wr_addr = clr_q;
        v_wr_data = '0;
        clr_d     = BW'(clr_q + 1'b1);
      end
      S_IDLE: begin
        if (accept) begin
          op_d         = op_e'(req_i.opcode);
          key_d        = {req_i.key_w3, req_i.key_w2, req_i.key_w1, req_i.key_w0};
          val_d        = {req_i.val_w3, req_i.val_w2, req_i.val_w1, req_i.val_w0};
          bucket_d     = req_i.key_w1[BW-1:0];
          way_d        = '0;
          hit_d        = 1'b0;
          vctrl.rd     = 1'b1;
          ectrl.key_rd = 1'b1;
          e_rd_addr    = slot_of(req_i.key_w1[BW-1:0], '0);
        end
      end
      S_PROBE: begin
        if (cmp) begin
          hit_d     = 1'b1;
          hit_way_d = way_q;
        end else if (!last_way) begin
          way_d        = WW'(way_q + 1'b1);
          ectrl.key_rd = 1'b1;
        end
      end
      S_EXEC: begin
        e_rd_addr = slot_of(bucket_q, hit_way_q);
        case (op_q)
          OP_INSERT: begin
            if (hit_q) begin
              res_d = STAT_MISS;
            end else if (!free_found) begin
              res_d = STAT_FULL;
            end else begin
              res_d              = STAT_OK;
              ectrl.wr           = 1'b1;
              vctrl.wr           = 1'b1;
              v_wr_data[free_way] = 1'b1;
            end
          end
          OP_LOOKUP: begin
            res_d        = hit_q ? STAT_OK : STAT_MISS;
            ectrl.val_rd = hit_q;
          end
          OP_REMOVE: begin
            res_d = hit_q ? STAT_OK : STAT_MISS;
            if (hit_q) begin
              vctrl.wr             = 1'b1;
              v_wr_data[hit_way_q] = 1'b0;
            end
          end
          default: res_d = STAT_MISS;
        endcase
      end
      S_DONE: begin
        if (load_out) begin
          out_vld_d    = 1'b1;
          out_status_d = res_q;
          out_data_d   = (op_q == OP_LOOKUP && res_q == STAT_OK) ? val_rd : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      way_q     <= '0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      way_q     <= way_d;
      hit_q     <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    bucket_q     <= bucket_d;
    hit_way_q    <= hit_way_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.out_w0 = out_data_q[WORD_W-1:0];
  assign rsp_o.out_w1 = out_data_q[2*WORD_W-1:WORD_W];
  assign rsp_o.out_w2 = out_data_q[3*WORD_W-1:2*WORD_W];
  assign rsp_o.out_w3 = out_data_q[4*WORD_W-1:3*WORD_W];

  `IHT_ASSERT_NEXT(a_accept_probes, accept, state_q == S_PROBE)
  `IHT_ASSERT_NEXT(a_clear_once, state_q != S_CLEAR, state_q != S_CLEAR)
  `IHT_ASSERT_NOW(a_way_bound, state_q == S_PROBE, way_q <= WW'(WAYS - 1))
  `IHT_ASSERT_NOW(a_data_only_on_hit,
                  rsp_o.valid && (out_data_q != '0), rsp_o.status == STAT_OK)

endmodule
